@@ rtl/cup_fill_brew_sequencer_assert.svh @@
// ----------------------------------------------------------------------------
// cup fill brew sequencer assertion macros
// shared property wrappers, clocked on the rising edge, quiet during reset
// ----------------------------------------------------------------------------
`ifndef CUP_FILL_BREW_SEQUENCER_ASSERT_SVH
`define CUP_FILL_BREW_SEQUENCER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define CFBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CFBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/cfbs_pkg.sv @@
// ----------------------------------------------------------------------------
// cfbs_pkg
// shared types and constants of the cup fill brew sequencer
// ----------------------------------------------------------------------------
package cfbs_pkg;

	// mode codes
	localparam logic [1:0] MODE_EMPTY   = 2'd0;
	localparam logic [1:0] MODE_BREWING = 2'd1;
	localparam logic [1:0] MODE_READY   = 2'd2;

	// register indexes (byte address 4*index)
	localparam logic [1:0] REG_BREW_TIME     = 2'd0;
	localparam logic [1:0] REG_FILL_CONFIRM  = 2'd1;
	localparam logic [1:0] REG_EMPTY_CONFIRM = 2'd2;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned SPAN_W = 24;

	// register reset values in milliseconds
	localparam logic [SPAN_W-1:0] BREW_TIME_RST     = 24'd20000;
	localparam logic [SPAN_W-1:0] FILL_CONFIRM_RST  = 24'd1500;
	localparam logic [SPAN_W-1:0] EMPTY_CONFIRM_RST = 24'd3000;

	typedef struct packed {
		logic [SPAN_W-1:0] brew_span;
		logic [SPAN_W-1:0] fill_span;
		logic [SPAN_W-1:0] empty_span;
	} cfg_t;

	typedef struct packed {
		logic       blue_led;
		logic       green_led;
		logic       teabag_down;
		logic       ready_pulse;
		logic [1:0] cup_state;
	} result_t;

endpackage

@@ rtl/cfbs_in_if.sv @@
// ----------------------------------------------------------------------------
// cfbs_in_if
// sample channel: fill switch level and millisecond timestamp
// ----------------------------------------------------------------------------
interface cfbs_in_if;
	logic        valid;
	logic        ready;
	logic        switch_active;
	logic [31:0] now_ms;

	modport source (output valid, output switch_active, output now_ms, input ready);
	modport sink (input valid, input switch_active, input now_ms, output ready);
endinterface

@@ rtl/cfbs_out_if.sv @@
// ----------------------------------------------------------------------------
// cfbs_out_if
// result channel: led drives, teabag position, ready pulse and state
// ----------------------------------------------------------------------------
interface cfbs_out_if;
	logic       valid;
	logic       ready;
	logic       blue_led;
	logic       green_led;
	logic       teabag_down;
	logic       ready_pulse;
	logic [1:0] cup_state;

	modport source (output valid, output blue_led, output green_led, output teabag_down,
		output ready_pulse, output cup_state, input ready);
	modport sink (input valid, input blue_led, input green_led, input teabag_down,
		input ready_pulse, input cup_state, output ready);
endinterface

@@ rtl/cfbs_core.sv @@
// ----------------------------------------------------------------------------
// cfbs_core
// cup state and stability timer, updated once per stepped sample
// ----------------------------------------------------------------------------
`include "cup_fill_brew_sequencer_assert.svh"

module cfbs_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic              switch_active,
	input  logic [31:0]       now_ms,
	input  cfbs_pkg::cfg_t    cfg,
	output cfbs_pkg::result_t result
);
	import cfbs_pkg::*;

	logic [1:0]        mode_q;
	logic [TIME_W-1:0] entered_q;
	logic              hold_run_q;
	logic [TIME_W-1:0] hold_start_q;

	logic [1:0]        mode_d;
	logic [TIME_W-1:0] entered_d;
	logic              hold_run_d;
	logic [TIME_W-1:0] hold_start_d;
	logic              pulse;

	logic [TIME_W-1:0] since_entry;
	logic [TIME_W-1:0] since_hold;
	logic [SPAN_W-1:0] confirm_span;
	logic              brew_done;
	logic              cond;
	logic              confirmed;

	// wraparound elapsed times and threshold compares
	assign since_entry  = now_ms - entered_q;
	assign since_hold   = now_ms - hold_start_q;
	assign brew_done    = since_entry >= {{(TIME_W-SPAN_W){1'b0}}, cfg.brew_span};
	assign cond         = (mode_q == MODE_READY) ? !switch_active : switch_active;
	assign confirm_span = (mode_q == MODE_READY) ? cfg.empty_span : cfg.fill_span;
	assign confirmed    = since_hold >= {{(TIME_W-SPAN_W){1'b0}}, confirm_span};

	// next state
	always_comb begin
		mode_d       = mode_q;
		entered_d    = entered_q;
		hold_run_d   = hold_run_q;
		hold_start_d = hold_start_q;
		pulse        = 1'b0;
		if (mode_q == MODE_BREWING) begin
			if (brew_done) begin
				mode_d       = MODE_READY;
				entered_d    = now_ms;
				hold_run_d   = 1'b0;
				hold_start_d = '0;
				pulse        = 1'b1;
			end
		end else if (!cond) begin
			hold_run_d   = 1'b0;
			hold_start_d = '0;
		end else if (!hold_run_q) begin
			hold_run_d   = 1'b1;
			hold_start_d = now_ms;
		end else if (confirmed) begin
			// ready drains to empty, empty (or the unused code) fills to brewing
			mode_d       = (mode_q == MODE_READY) ? MODE_EMPTY : MODE_BREWING;
			entered_d    = now_ms;
			hold_run_d   = 1'b0;
			hold_start_d = '0;
		end
	end

	// result seen after the update
	always_comb begin
		result.blue_led    = (mode_d == MODE_BREWING);
		result.green_led   = (mode_d == MODE_READY);
		result.teabag_down = (mode_d != MODE_READY);
		result.ready_pulse = pulse;
		result.cup_state   = mode_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EMPTY;
			entered_q    <= '0;
			hold_run_q   <= 1'b0;
			hold_start_q <= '0;
		end else if (step) begin
			mode_q       <= mode_d;
			entered_q    <= entered_d;
			hold_run_q   <= hold_run_d;
			hold_start_q <= hold_start_d;
		end
	end

	`CFBS_ASSERT_NEXT(a_change_clears_hold, clk, arst_n, step && (mode_d != mode_q),
		!hold_run_q && (hold_start_q == '0), "state change left stability timer running")
	`CFBS_ASSERT_NEXT(a_brew_holds, clk, arst_n, step && (mode_q == MODE_BREWING) && !brew_done,
		mode_q == MODE_BREWING, "left brewing before brew time elapsed")
	`CFBS_ASSERT_NEXT(a_brew_no_hold, clk, arst_n, step && (mode_d == MODE_BREWING),
		!hold_run_q, "stability timer running while brewing")

endmodule

@@ rtl/cup_fill_brew_sequencer.sv @@
// ----------------------------------------------------------------------------
// cup_fill_brew_sequencer
// fill switch sampler driving the empty / brewing / ready cup sequence
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one fill switch sample with its millisecond timestamp per
//   beat; out_ch returns exactly one result beat per sample, in order.
//   From input beat to result valid, the sample is registered, the state
//   update and result are computed in one short pass (32-bit subtracts and
//   compares against the stored times), and the result is registered. A new
//   sample is taken every cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds its beat and the
//   input register keeps one more sample; in_ch.ready drops only when both
//   are full, so nothing is lost or repeated.
//   Reset puts the cup in the empty state with the stability timer idle and
//   loads the timing registers with 20000, 1500 and 3000 ms.
//   The APB port holds the three 24-bit timing registers at byte addresses
//   0, 4 and 8; write them only while no sample is in flight.
// ----------------------------------------------------------------------------
`include "cup_fill_brew_sequencer_assert.svh"

module cup_fill_brew_sequencer (
	input  logic                        clk,
	input  logic                        arst_n,
	cfbs_in_if.sink                     in_ch,
	cfbs_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfbs_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import cfbs_pkg::*;

	logic [SPAN_W-1:0] brew_q;
	logic [SPAN_W-1:0] fill_q;
	logic [SPAN_W-1:0] empty_q;
	logic [1:0]        reg_idx;
	logic              wr_en;
	cfg_t              cfg;

	logic              v_s1;
	logic              sw_s1;
	logic [TIME_W-1:0] now_s1;
	logic              v_s2;
	result_t           res_s2;
	result_t           res_next;
	logic              adv;
	logic              step;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brew_q  <= BREW_TIME_RST;
			fill_q  <= FILL_CONFIRM_RST;
			empty_q <= EMPTY_CONFIRM_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BREW_TIME:     brew_q  <= pwdata[SPAN_W-1:0];
				REG_FILL_CONFIRM:  fill_q  <= pwdata[SPAN_W-1:0];
				REG_EMPTY_CONFIRM: empty_q <= pwdata[SPAN_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_BREW_TIME:     prdata = {{(32-SPAN_W){1'b0}}, brew_q};
			REG_FILL_CONFIRM:  prdata = {{(32-SPAN_W){1'b0}}, fill_q};
			REG_EMPTY_CONFIRM: prdata = {{(32-SPAN_W){1'b0}}, empty_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.brew_span  = brew_q;
	assign cfg.fill_span  = fill_q;
	assign cfg.empty_span = empty_q;

	// pipeline flow control
	assign adv         = !v_s2 || out_ch.ready;
	assign step        = v_s1 && adv;
	assign in_ch.ready = !v_s1 || adv;

	// input sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sw_s1  <= in_ch.switch_active;
			now_s1 <= in_ch.now_ms;
		end
	end

	cfbs_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.switch_active (sw_s1),
		.now_ms        (now_s1),
		.cfg           (cfg),
		.result        (res_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_next;
		end
	end

	assign out_ch.valid       = v_s2;
	assign out_ch.blue_led    = res_s2.blue_led;
	assign out_ch.green_led   = res_s2.green_led;
	assign out_ch.teabag_down = res_s2.teabag_down;
	assign out_ch.ready_pulse = res_s2.ready_pulse;
	assign out_ch.cup_state   = res_s2.cup_state;

	`CFBS_ASSERT_NEXT(a_s1_kept, clk, arst_n, v_s1 && !adv, v_s1,
		"stalled sample dropped from input register")
	`CFBS_ASSERT_NEXT(a_step_delivers, clk, arst_n, step, v_s2,
		"stepped sample produced no result beat")
	`CFBS_ASSERT_NEXT(a_brew_write, clk, arst_n, wr_en && (reg_idx == REG_BREW_TIME),
		brew_q == $past(pwdata[SPAN_W-1:0]), "brew time register write lost")

endmodule

@@ verif/tb_cup_fill_brew_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cup_fill_brew_sequencer
// feeds timestamped fill switch samples into the cup sequencer under random
// idling on both channels, programs the timing registers over APB between
// phases, and checks every result beat against a cycle-free model of the
// empty / brewing / ready sequence kept in a small scoreboard class
// ----------------------------------------------------------------------------
module tb_cup_fill_brew_sequencer;
	import cfbs_pkg::*;

	// index with no register behind it, writes to it are dropped
	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam logic [SPAN_W-1:0] SPAN_MAX = 24'hFFFFFF;

	// expected cup behavior and result checking
	class cup_scoreboard;
		logic [SPAN_W-1:0] brew_span;
		logic [SPAN_W-1:0] fill_span;
		logic [SPAN_W-1:0] empty_span;
		logic [1:0]        cup_mode;
		logic [TIME_W-1:0] entered_at;
		bit                hold_on;
		logic [TIME_W-1:0] hold_since;
		result_t           expected_cup_results[$];
		int unsigned       mismatches;
		int unsigned       beats_seen;

		function new();
			brew_span = BREW_TIME_RST;
			fill_span = FILL_CONFIRM_RST;
			empty_span = EMPTY_CONFIRM_RST;
			cup_mode = MODE_EMPTY;
			entered_at = '0;
			hold_on = 1'b0;
			hold_since = '0;
			mismatches = 0;
			beats_seen = 0;
		endfunction

		function void set_register(logic [1:0] index, logic [31:0] value);
			case (index)
				REG_BREW_TIME: brew_span = value[SPAN_W-1:0];
				REG_FILL_CONFIRM: fill_span = value[SPAN_W-1:0];
				REG_EMPTY_CONFIRM: empty_span = value[SPAN_W-1:0];
				default: ;
			endcase
		endfunction

		// wraparound difference against the 24-bit span
		function bit elapsed(logic [TIME_W-1:0] t, logic [TIME_W-1:0] since,
			logic [SPAN_W-1:0] span);
			logic [TIME_W-1:0] diff_ms;
			diff_ms = t - since;
			return diff_ms >= {8'd0, span};
		endfunction

		// stability timer: first good sample only arms it, a bad one clears it
		function bit held(bit cond, logic [TIME_W-1:0] t, logic [SPAN_W-1:0] span);
			if (!cond) begin
				hold_on = 1'b0;
				hold_since = '0;
				return 1'b0;
			end
			if (!hold_on) begin
				hold_on = 1'b1;
				hold_since = t;
				return 1'b0;
			end
			return elapsed(t, hold_since, span);
		endfunction

		function void enter(logic [1:0] next_mode, logic [TIME_W-1:0] t);
			cup_mode = next_mode;
			entered_at = t;
			hold_on = 1'b0;
			hold_since = '0;
		endfunction

		// advance the cup state by one accepted sample and queue its result
		function void note_sample(bit sw, logic [TIME_W-1:0] t);
			result_t r;
			bit      pulse;
			pulse = 1'b0;
			case (cup_mode)
				MODE_BREWING: begin
					if (elapsed(t, entered_at, brew_span)) begin
						enter(MODE_READY, t);
						pulse = 1'b1;
					end
				end
				MODE_READY: begin
					if (held(!sw, t, empty_span))
						enter(MODE_EMPTY, t);
				end
				default: begin
					if (held(sw, t, fill_span))
						enter(MODE_BREWING, t);
				end
			endcase
			r.blue_led = (cup_mode == MODE_BREWING);
			r.green_led = (cup_mode == MODE_READY);
			r.teabag_down = (cup_mode != MODE_READY);
			r.ready_pulse = pulse;
			r.cup_state = cup_mode;
			expected_cup_results.push_back(r);
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task compare_field(string name, logic [1:0] got, logic [1:0] want);
			if (got !== want)
				report_mismatch($sformatf("beat %0d %s got %0d want %0d",
					beats_seen, name, got, want));
		endtask

		task check_result(result_t got);
			result_t want;
			if (expected_cup_results.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with nothing expected",
					beats_seen));
			end else begin
				want = expected_cup_results.pop_front();
				compare_field("blue_led", {1'b0, got.blue_led}, {1'b0, want.blue_led});
				compare_field("green_led", {1'b0, got.green_led}, {1'b0, want.green_led});
				compare_field("teabag_down", {1'b0, got.teabag_down},
					{1'b0, want.teabag_down});
				compare_field("ready_pulse", {1'b0, got.ready_pulse},
					{1'b0, want.ready_pulse});
				compare_field("cup_state", got.cup_state, want.cup_state);
			end
			beats_seen++;
		endtask
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	cfbs_in_if  in_ch ();
	cfbs_out_if out_ch ();

	cup_scoreboard     sb;
	int unsigned       gap_pct;
	int unsigned       stall_pct;
	logic [TIME_W-1:0] clock_ms;

	cup_fill_brew_sequencer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the run hangs
	initial begin
		#6000000;
		$display("== FAIL ==");
		$finish;
	end

	// result receiver with random stalls, mostly short
	initial begin : result_sink
		int unsigned stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < stall_pct) begin
				out_ch.ready <= 1'b0;
				stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
					: $urandom_range(0, 2);
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// check each accepted result beat
	always @(posedge clk) begin : result_watch
		result_t beat;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			beat.blue_led = out_ch.blue_led;
			beat.green_led = out_ch.green_led;
			beat.teabag_down = out_ch.teabag_down;
			beat.ready_pulse = out_ch.ready_pulse;
			beat.cup_state = out_ch.cup_state;
			sb.check_result(beat);
		end
	end

	// one sample beat, then maybe a gap
	task automatic feed_sample(bit sw, logic [TIME_W-1:0] t);
		int unsigned n;
		in_ch.valid <= 1'b1;
		in_ch.switch_active <= sw;
		in_ch.now_ms <= t;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_sample(sw, t);
		if ($urandom_range(0, 99) < gap_pct) begin
			in_ch.valid <= 1'b0;
			n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
			repeat (n) @(posedge clk);
		end
	endtask

	// stop sending and wait until every expected beat has come back
	task automatic settle();
		in_ch.valid <= 1'b0;
		while (sb.expected_cup_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write, then read back where a register exists, then return the bus to idle
	task automatic write_register(logic [1:0] index, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.set_register(index, data);
		if (index != REG_UNUSED) begin
			pwrite <= 1'b0;
			penable <= 1'b0;
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (pready !== 1'b1);
			if (prdata[SPAN_W-1:0] !== data[SPAN_W-1:0])
				sb.report_mismatch($sformatf("register %0d reads %0h want %0h",
					index, prdata[SPAN_W-1:0], data[SPAN_W-1:0]));
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// junk in the upper bits must be dropped by the 24-bit registers
	task automatic program_spans(logic [SPAN_W-1:0] brew, logic [SPAN_W-1:0] fill,
		logic [SPAN_W-1:0] empty);
		logic [7:0] junk;
		junk = 8'($urandom);
		write_register(REG_BREW_TIME, {junk, brew});
		junk = 8'($urandom);
		write_register(REG_FILL_CONFIRM, {junk, fill});
		junk = 8'($urandom);
		write_register(REG_EMPTY_CONFIRM, {junk, empty});
	endtask

	// switch held in runs so the timers confirm, with flips and time jumps
	task automatic run_random(int unsigned count, int unsigned step_max);
		bit          level;
		bit          sw;
		int unsigned run_left;
		int unsigned roll;
		level = 1'b0;
		run_left = 0;
		for (int unsigned i = 0; i < count; i++) begin
			if (run_left == 0) begin
				level = !level;
				run_left = $urandom_range(1, 12);
			end
			run_left--;
			sw = ($urandom_range(0, 99) < 6) ? !level : level;
			roll = $urandom_range(0, 99);
			if (roll < 4)
				clock_ms = $urandom;
			else if (roll < 7)
				clock_ms = clock_ms - $urandom_range(1, step_max);
			else
				clock_ms = clock_ms + $urandom_range(0, step_max);
			feed_sample(sw, clock_ms);
		end
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.switch_active <= 1'b0;
		in_ch.now_ms <= '0;
		gap_pct = 20;
		stall_pct = 20;
		clock_ms = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: fill confirm exactly at the span, brew, ready
		feed_sample(1'b1, 32'd0);
		feed_sample(1'b1, 32'd1499);
		feed_sample(1'b1, 32'd1500);
		feed_sample(1'b0, 32'd21499);
		feed_sample(1'b1, 32'd21500);
		// ready: active switch clears the timer, a break restarts it
		feed_sample(1'b1, 32'd21600);
		feed_sample(1'b0, 32'd21700);
		feed_sample(1'b1, 32'd22000);
		feed_sample(1'b0, 32'd22100);
		feed_sample(1'b0, 32'd25099);
		feed_sample(1'b0, 32'd25100);
		// time running backwards counts as elapsed
		feed_sample(1'b1, 32'd30000);
		feed_sample(1'b1, 32'd100);
		feed_sample(1'b0, 32'd50);
		// empty confirm across the 32-bit wrap
		feed_sample(1'b0, 32'hFFFF_FF00);
		feed_sample(1'b0, 32'h0000_0AB8);

		// zero spans: second good sample confirms, brewing ends at once
		settle();
		write_register(REG_UNUSED, $urandom);
		program_spans('0, '0, '0);
		feed_sample(1'b1, 32'h8000_0000);
		feed_sample(1'b1, 32'h8000_0000);
		feed_sample(1'b0, 32'h8000_0000);
		feed_sample(1'b0, 32'h8000_0001);
		feed_sample(1'b0, 32'h8000_0001);

		// largest spans, one short and then exactly on the span
		settle();
		program_spans(SPAN_MAX, SPAN_MAX, SPAN_MAX);
		feed_sample(1'b1, 32'h0000_0000);
		feed_sample(1'b1, 32'h00FF_FFFE);
		feed_sample(1'b1, 32'h00FF_FFFF);
		feed_sample(1'b1, 32'h01FF_FFFE);

		// short spans, the sender waits out every result midway
		settle();
		program_spans(SPAN_W'($urandom_range(0, 40)), SPAN_W'($urandom_range(0, 15)),
			SPAN_W'($urandom_range(0, 15)));
		run_random(120, 8);
		settle();
		run_random(130, 8);

		settle();
		program_spans('0, '0, '0);
		run_random(150, 3);

		settle();
		program_spans(SPAN_W'($urandom), SPAN_W'($urandom), SPAN_W'($urandom));
		run_random(150, 1 << 22);

		settle();
		program_spans(SPAN_MAX, SPAN_MAX, SPAN_MAX);
		run_random(150, 1 << 23);

		// back to back beats with no idling
		settle();
		gap_pct = 0;
		stall_pct = 0;
		program_spans(SPAN_W'($urandom_range(0, 40)), SPAN_W'($urandom_range(0, 15)),
			SPAN_W'($urandom_range(0, 15)));
		run_random(200, 8);

		settle();
		gap_pct = 20;
		stall_pct = 20;
		program_spans(BREW_TIME_RST, FILL_CONFIRM_RST, EMPTY_CONFIRM_RST);
		run_random(150, 2000);

		in_ch.valid <= 1'b0;
		while (sb.expected_cup_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_cup_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
